// ===== design/plf_pkg.sv =====
// Shared types, constants and operation codes of the power-law fit block.
`default_nettype none

package plf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int POINTS_W   = 11;
  localparam int X_W        = 27;

  localparam logic [5:0]  MASS_FRAC_BITS  = 6'd48;
  localparam logic [5:0]  SPEED_FRAC_BITS = 6'd22;
  localparam logic [31:0] LN2_Q32         = 32'd2977044472;
  localparam logic [63:0] LOG2E_Q32       = 64'd6196328019;
  localparam logic [63:0] LN2_Q64         = 64'hB17217F7D1CF79AC;
  localparam logic [63:0] EXP_ONE         = 64'h4000_0000_0000_0000;
  localparam logic [4:0]  EXP_TERMS       = 5'd24;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [3:0] OP_DEN_A    = 4'd0;
  localparam logic [3:0] OP_DEN_B    = 4'd1;
  localparam logic [3:0] OP_K1_A     = 4'd2;
  localparam logic [3:0] OP_K1_B     = 4'd3;
  localparam logic [3:0] OP_K1_DIV   = 4'd4;
  localparam logic [3:0] OP_K0_A     = 4'd5;
  localparam logic [3:0] OP_K0_B     = 4'd6;
  localparam logic [3:0] OP_K0_DIV   = 4'd7;
  localparam logic [3:0] OP_EXP_T    = 4'd8;
  localparam logic [3:0] OP_EXP_U    = 4'd9;
  localparam logic [3:0] OP_TERM_MUL = 4'd10;
  localparam logic [3:0] OP_TERM_DIV = 4'd11;

  typedef struct packed {
    logic [47:0] mass_value;
    logic [31:0] speed_value;
    logic        last_point;
  } pair_t;

  typedef struct packed {
    logic signed [47:0] exponent;
    logic signed [47:0] log_coefficient;
    logic [63:0]        coefficient;
    logic [10:0]        points_used;
    logic [1:0]         fit_status;
  } result_t;

  typedef struct packed {
    logic       log_go;
    logic       set_ovf;
    logic       prod_go;
    logic       acc_go;
    logic       op_go;
    logic [3:0] op;
    logic [4:0] term_k;
    logic       emit;
  } plf_cmd_t;

  typedef struct packed {
    logic full;
    logic logs_ready;
    logic unit_done;
    logic den_zero;
  } plf_stat_t;

endpackage

`default_nettype wire

// ===== design/plf_log.sv =====
// Iterative natural logarithm unit: normalise, square for log2 bits, scale by ln 2.
`default_nettype none

module plf_log import plf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [63:0]        value,
  input  wire logic [5:0]         frac_bits,
  output logic                    ready,
  output logic signed [X_W-1:0]   ln_value
);

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_NORM  = 3'd1;
  localparam logic [2:0] L_SQ    = 3'd2;
  localparam logic [2:0] L_SCALE = 3'd3;
  localparam logic [2:0] L_ROUND = 3'd4;

  logic [2:0]         phase;
  logic [4:0]         cnt;
  logic [63:0]        v;
  logic [5:0]         sh;
  logic [5:0]         fb;
  logic [31:0]        m;
  logic [23:0]        f;
  logic signed [63:0] scaled;

  logic [6:0]         w;
  logic               top_zero;
  logic [63:0]        sq;
  logic signed [7:0]  expo;
  logic signed [30:0] log2_q24;
  logic [63:0]        mag;
  logic [27:0]        rounded;

  always_comb begin
    w        = 7'd32 >> cnt[2:0];
    top_zero = (v >> (7'd64 - w)) == 64'd0;
    sq       = m * m;
    expo     = 8'sd63 - $signed({2'b00, sh}) - $signed({2'b00, fb});
    log2_q24 = {expo[6:0], f};
    mag      = scaled[63] ? 64'(-scaled) : 64'(scaled);
    rounded  = 28'((mag + 64'h8_0000_0000) >> 36);
  end

  assign ready = (phase == L_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= L_IDLE;
    end else begin
      unique case (phase)
        L_IDLE: begin
          if (start) begin
            phase <= L_NORM;
          end
        end
        L_NORM: begin
          if (cnt == 5'd5) begin
            phase <= L_SQ;
          end
        end
        L_SQ: begin
          if (cnt == 5'd23) begin
            phase <= L_SCALE;
          end
        end
        L_SCALE: phase <= L_ROUND;
        L_ROUND: phase <= L_IDLE;
        default: phase <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      L_IDLE: begin
        if (start) begin
          v   <= (value == 64'd0) ? 64'd1 : value;
          sh  <= 6'd0;
          cnt <= 5'd0;
          fb  <= frac_bits;
        end
      end
      L_NORM: begin
        // Binary search for the leading one, halving the step each cycle.
        if (top_zero) begin
          v  <= v << w;
          sh <= sh + 6'(w);
        end
        if (cnt == 5'd5) begin
          m   <= top_zero ? v[62:31] : v[63:32];
          f   <= 24'd0;
          cnt <= 5'd0;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      L_SQ: begin
        m   <= sq[63] ? sq[63:32] : sq[62:31];
        f   <= {f[22:0], sq[63]};
        cnt <= cnt + 5'd1;
      end
      L_SCALE: begin
        scaled <= log2_q24 * $signed({1'b0, LN2_Q32});
      end
      L_ROUND: begin
        ln_value <= X_W'(scaled[63] ? 28'(-rounded) : rounded);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/plf_mul.sv =====
// Multi-cycle 64 by 64 multiplier built from four 32 by 32 partial products.
`default_nettype none

module plf_mul import plf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  input  wire logic         sgn,
  output logic [127:0]      prod,
  output logic              done
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic         run;
  logic [2:0]   step;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] acc;

  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp_next;
  logic [127:0] shifted;

  always_comb begin
    a_part = step[1] ? ma[63:32] : ma[31:0];
    b_part = step[0] ? mb[63:32] : mb[31:0];
    pp_next = a_part * b_part;
    case (pp_pos)
      2'd0:    shifted = {64'd0, pp};
      2'd1:    shifted = {32'd0, pp, 32'd0};
      default: shifted = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && step == 3'd5) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ma   <= (sgn && a[63]) ? 64'(-a) : a;
      mb   <= (sgn && b[63]) ? 64'(-b) : b;
      neg  <= sgn && (a[63] ^ b[63]);
      step <= 3'd0;
      acc  <= 128'd0;
    end else if (run) begin
      step <= step + 3'd1;
      if (step < 3'd4) begin
        pp     <= pp_next;
        pp_pos <= (step == 3'd0) ? 2'd0 : ((step == 3'd3) ? 2'd2 : 2'd1);
      end
      if (step != 3'd0 && step != 3'd5) begin
        acc <= acc + shifted;
      end
      if (step == 3'd5) begin
        prod <= neg ? 128'(-acc) : acc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/plf_div.sv =====
// Restoring 128-bit unsigned divider, one quotient bit per cycle, with a round-half flag.
`default_nettype none

module plf_div import plf_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [127:0]  num,
  input  wire logic [127:0]  den,
  output logic [127:0]       quo,
  output logic               half,
  output logic               done
);

  logic [127:0] n_sh;
  logic [127:0] d;
  logic [127:0] r;
  logic [6:0]   cnt;
  logic         run;
  logic         fin;

  logic [127:0] r2;
  logic         ge;

  always_comb begin
    r2 = {r[126:0], n_sh[127]};
    ge = (r2 >= d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && cnt == 7'd127) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_sh <= num;
      d    <= den;
      quo  <= 128'd0;
      r    <= 128'd0;
      cnt  <= 7'd0;
    end else if (run) begin
      r    <= ge ? (r2 - d) : r2;
      quo  <= {quo[126:0], ge};
      n_sh <= n_sh << 1;
      cnt  <= cnt + 7'd1;
    end else if (fin) begin
      // Remainder at least half the divisor rounds the magnitude up.
      half <= (r >= (d - r));
    end
  end

endmodule

`default_nettype wire

// ===== design/plf_dp.sv =====
// Datapath: logarithm units, sums, shared multiplier and divider, exp series, result register.
`default_nettype none

module plf_dp import plf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pair_t     pair,
  input  wire plf_cmd_t  cmd,
  output plf_stat_t      stat,
  output result_t        result,
  output logic           done
);

  logic                  mass_ready;
  logic                  speed_ready;
  logic signed [X_W-1:0] x;
  logic signed [X_W-1:0] y;

  logic signed [53:0]    xy;
  logic signed [53:0]    xx;
  logic [POINTS_W-1:0]   count;
  logic [47:0]           sx;
  logic [47:0]           sy;
  logic [63:0]           sxy;
  logic [63:0]           sxx;
  logic                  ovf;

  logic [127:0]          den;
  logic [127:0]          num;
  logic [47:0]           k1;
  logic [47:0]           k0;
  logic [127:0]          t;
  logic [63:0]           u;
  logic [63:0]           term;
  logic [63:0]           esum;
  logic [63:0]           prodhi;
  logic                  qneg;

  logic                  is_div;
  logic                  mul_go;
  logic                  div_go;
  logic [63:0]           mul_a;
  logic [63:0]           mul_b;
  logic                  mul_sgn;
  logic [127:0]          mul_p;
  logic                  mul_done;
  logic [127:0]          div_n;
  logic [127:0]          div_d;
  logic [127:0]          div_q;
  logic                  div_half;
  logic                  div_done;

  logic [63:0]           sx64;
  logic [63:0]           sy64;
  logic [127:0]          q_rnd;
  logic [127:0]          limit;
  logic [47:0]           q48;
  logic [47:0]           k_val;
  logic signed [63:0]    ip;
  logic [5:0]            shamt;
  logic [63:0]           coef;

  plf_log u_log_mass (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.log_go),
    .value     ({16'd0, pair.mass_value}),
    .frac_bits (MASS_FRAC_BITS),
    .ready     (mass_ready),
    .ln_value  (x)
  );

  plf_log u_log_speed (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.log_go),
    .value     ({32'd0, pair.speed_value}),
    .frac_bits (SPEED_FRAC_BITS),
    .ready     (speed_ready),
    .ln_value  (y)
  );

  plf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .sgn  (mul_sgn),
    .prod (mul_p),
    .done (mul_done)
  );

  plf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_n),
    .den  (div_d),
    .quo  (div_q),
    .half (div_half),
    .done (div_done)
  );

  always_comb begin
    sx64   = {{16{sx[47]}}, sx};
    sy64   = {{16{sy[47]}}, sy};
    is_div = (cmd.op == OP_K1_DIV) || (cmd.op == OP_K0_DIV) || (cmd.op == OP_TERM_DIV);
    mul_go = cmd.op_go && !is_div;
    div_go = cmd.op_go && is_div;

    mul_sgn = 1'b1;
    unique case (cmd.op)
      OP_DEN_A:    begin mul_a = {53'd0, count}; mul_b = sxx; end
      OP_DEN_B:    begin mul_a = sx64; mul_b = sx64; end
      OP_K1_A:     begin mul_a = {53'd0, count}; mul_b = sxy; end
      OP_K1_B:     begin mul_a = sx64; mul_b = sy64; end
      OP_K0_A:     begin mul_a = sxx; mul_b = sy64; end
      OP_K0_B:     begin mul_a = sx64; mul_b = sxy; end
      OP_EXP_T:    begin mul_a = {{16{k0[47]}}, k0}; mul_b = LOG2E_Q32; end
      OP_EXP_U:    begin mul_a = t[63:0]; mul_b = LN2_Q64; mul_sgn = 1'b0; end
      OP_TERM_MUL: begin mul_a = term; mul_b = u; mul_sgn = 1'b0; end
      default:     begin mul_a = 64'd0; mul_b = 64'd0; end
    endcase

    if (cmd.op == OP_TERM_DIV) begin
      div_n = {64'd0, prodhi};
      div_d = 128'(cmd.term_k);
    end else begin
      div_n = num[127] ? 128'(-num) : num;
      div_d = den[127] ? 128'(-den) : den;
    end

    // Round half away from zero, then clamp to the signed 48-bit range.
    q_rnd = div_q + 128'(div_half);
    limit = qneg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    q48   = (q_rnd > limit) ? limit[47:0] : q_rnd[47:0];
    k_val = qneg ? 48'(-q48) : q48;

    // Scale the Q2.62 mantissa by two to the integer part.
    ip    = $signed(t[127:64]);
    shamt = 6'(7'd30 - ip[6:0]);
    if (ip >= 64'sd32) begin
      coef = '1;
    end else if (ip == 64'sd31) begin
      coef = esum[63] ? '1 : (esum << 1);
    end else if (ip == 64'sd30) begin
      coef = esum;
    end else if (ip < -64'sd33) begin
      coef = 64'd0;
    end else begin
      coef = (esum + (64'd1 << (shamt - 6'd1))) >> shamt;
    end

    stat.full       = (count == POINTS_W'(MAX_POINTS));
    stat.logs_ready = mass_ready && speed_ready;
    stat.unit_done  = mul_done || div_done;
    stat.den_zero   = (den == 128'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sx    <= '0;
      sy    <= '0;
      sxy   <= '0;
      sxx   <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.emit) begin
        count <= '0;
        sx    <= '0;
        sy    <= '0;
        sxy   <= '0;
        sxx   <= '0;
        ovf   <= 1'b0;
      end else begin
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
        if (cmd.acc_go) begin
          sx    <= sx + {{21{x[X_W-1]}}, x};
          sy    <= sy + {{21{y[X_W-1]}}, y};
          sxy   <= sxy + {{10{xy[53]}}, xy};
          sxx   <= sxx + {{10{xx[53]}}, xx};
          count <= count + POINTS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_go) begin
      xy <= x * y;
      xx <= x * x;
    end
    if (div_go) begin
      qneg <= num[127] ^ den[127];
    end
    if (mul_done) begin
      case (cmd.op)
        OP_DEN_A:    den <= mul_p;
        OP_DEN_B:    den <= den - mul_p;
        OP_K1_A:     num <= mul_p;
        OP_K1_B:     num <= (num - mul_p) << 32;
        OP_K0_A:     num <= mul_p;
        OP_K0_B:     num <= (num - mul_p) << 12;
        OP_EXP_T:    t <= mul_p;
        OP_EXP_U: begin
          u    <= mul_p[127:64];
          term <= EXP_ONE;
          esum <= EXP_ONE;
        end
        OP_TERM_MUL: prodhi <= mul_p[127:64];
        default: begin
        end
      endcase
    end
    if (div_done) begin
      case (cmd.op)
        OP_K1_DIV:   k1 <= k_val;
        OP_K0_DIV:   k0 <= k_val;
        OP_TERM_DIV: begin
          term <= div_q[63:0];
          esum <= esum + div_q[63:0];
        end
        default: begin
        end
      endcase
    end
    if (cmd.emit) begin
      result.points_used <= count;
      if (stat.den_zero) begin
        result.exponent        <= '0;
        result.log_coefficient <= '0;
        result.coefficient     <= '0;
        result.fit_status      <= ST_SINGULAR;
      end else begin
        result.exponent        <= k1;
        result.log_coefficient <= k0;
        result.coefficient     <= coef;
        result.fit_status      <= ovf ? ST_OVERFLOW : ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/plf_ctrl.sv =====
// Controller: sequences the logarithms, accumulation and the fit operations.
`default_nettype none

module plf_ctrl import plf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       last_point,
  input  wire plf_stat_t  stat,
  output plf_cmd_t        cmd,
  output logic            busy
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_LOG   = 3'd1;
  localparam logic [2:0] C_PROD  = 3'd2;
  localparam logic [2:0] C_ACC   = 3'd3;
  localparam logic [2:0] C_ISSUE = 3'd4;
  localparam logic [2:0] C_WAIT  = 3'd5;
  localparam logic [2:0] C_NEXT  = 3'd6;
  localparam logic [2:0] C_EMIT  = 3'd7;

  logic [2:0] state;
  logic [3:0] op;
  logic [4:0] k;
  logic       last_r;
  logic       accept;

  always_comb begin
    accept      = start && (state == C_IDLE);
    cmd.log_go  = accept && !stat.full;
    cmd.set_ovf = accept && stat.full;
    cmd.prod_go = (state == C_PROD);
    cmd.acc_go  = (state == C_ACC);
    cmd.op_go   = (state == C_ISSUE);
    cmd.op      = op;
    cmd.term_k  = k;
    cmd.emit    = (state == C_EMIT);
    busy        = (state != C_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      op     <= OP_DEN_A;
      k      <= 5'd1;
      last_r <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            last_r <= last_point;
            if (!stat.full) begin
              state <= C_LOG;
            end else if (last_point) begin
              // A word beyond the limit still closes the data set.
              op    <= OP_DEN_A;
              state <= C_ISSUE;
            end
          end
        end
        C_LOG: begin
          if (stat.logs_ready) begin
            state <= C_PROD;
          end
        end
        C_PROD: state <= C_ACC;
        C_ACC: begin
          if (last_r) begin
            op    <= OP_DEN_A;
            state <= C_ISSUE;
          end else begin
            state <= C_IDLE;
          end
        end
        C_ISSUE: state <= C_WAIT;
        C_WAIT: begin
          if (stat.unit_done) begin
            state <= C_NEXT;
          end
        end
        C_NEXT: begin
          if (op == OP_DEN_B && stat.den_zero) begin
            state <= C_EMIT;
          end else if (op == OP_TERM_DIV) begin
            if (k == EXP_TERMS) begin
              state <= C_EMIT;
            end else begin
              k     <= k + 5'd1;
              op    <= OP_TERM_MUL;
              state <= C_ISSUE;
            end
          end else if (op == OP_EXP_U) begin
            k     <= 5'd1;
            op    <= OP_TERM_MUL;
            state <= C_ISSUE;
          end else begin
            op    <= op + 4'd1;
            state <= C_ISSUE;
          end
        end
        C_EMIT: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/power_law_fit.sv =====
// Power-law least-squares fit: top level joining controller and datapath.
// The time for a pair that is not the last is dominated by the 24 squarings of the log units.
// A last pair adds the fit, whose time is dominated by the bit-per-cycle
// 128-bit divider (two quotients plus 24 series terms) and the multiplier.
// The result word is shown with done for one cycle; busy is low again in that cycle.
// Synchronous rst clears the sums, the count and the overflow flag at once.
`default_nettype none

module power_law_fit import plf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire pair_t pair,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  plf_cmd_t  cmd;
  plf_stat_t stat;

  plf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (pair.last_point),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  plf_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_log_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !stat.full) |=> busy)
    else $error("accepted word did not start work");

  a_emit_done: assert property (@(posedge clk) disable iff (rst) cmd.emit |=> done)
    else $error("emit without result strobe");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.fit_status == ST_SINGULAR) |->
      (result.exponent == '0 && result.coefficient == '0))
    else $error("singular fit with non-zero result");

endmodule

`default_nettype wire

// ===== test/power_law_fit_tb.sv =====
// Self-checking testbench for the power-law least-squares fit block.
`timescale 1ns / 100ps

module power_law_fit_tb;
  import plf_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int RANDOM_PAIRS = 300;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  pair_t   pair = '0;
  logic    busy;
  logic    done;
  result_t result;

  result_t fit_expected_q[$];
  int      error_count = 0;
  int      pairs_sent = 0;
  int      fits_checked = 0;
  int      cycle_count = 0;
  int      idle_pct = 0;

  // Running count and sums of the logarithms, widths as in the block.
  logic [10:0] n_pairs;
  logic [47:0] sum_x, sum_y;
  logic [63:0] sum_xy, sum_xx;
  logic        too_many;

  power_law_fit dut (
    .clk(clk), .rst(rst), .start(start), .pair(pair),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint log_q20(input logic [63:0] v, input int fb);
    int          p;
    logic [63:0] m;
    logic [23:0] f;
    longint      acc, mag;
    if (v == 0) v = 1;
    p = 0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        p = i;
        break;
      end
    end
    m = (p <= 31) ? (v << (31 - p)) : (v >> (p - 31));
    f = '0;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f[i] = 1'b1;
      end
    end
    acc = (longint'(p - fb) * 16777216 + longint'(f)) * longint'(LN2_Q32);
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + (64'sd1 <<< 35)) >>> 36;
    return (acc < 0) ? -mag : mag;
  endfunction

  // Quotient rounded half away from zero, then clamped to 48 signed bits.
  function automatic longint quotient_sat(input logic [127:0] num, input logic [127:0] den);
    logic         neg_n, neg_d;
    logic [127:0] q, r;
    logic [63:0]  lim;
    neg_n = num[127];
    neg_d = den[127];
    if (neg_n) num = -num;
    if (neg_d) den = -den;
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    lim = (neg_n != neg_d) ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    if (q[127:64] != 0 || q[63:0] > lim) q[63:0] = lim;
    return (neg_n != neg_d) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [63:0] coefficient_of(input longint k0);
    logic signed [127:0] t;
    logic [127:0]        prod;
    logic [63:0]         u, sum, term;
    longint              ip;
    int                  s;
    t = {{64{k0[63]}}, k0} * {64'b0, LOG2E_Q32};
    prod = {64'b0, t[63:0]} * {64'b0, LN2_Q64};
    u = prod[127:64];
    sum = EXP_ONE;
    term = EXP_ONE;
    for (int k = 1; k <= 24; k++) begin
      prod = {64'b0, term} * {64'b0, u};
      term = prod[127:64] / k;
      sum = sum + term;
    end
    ip = longint'(t[127:64]);
    if (ip >= 32) return '1;
    if (ip == 31) return sum[63] ? '1 : (sum << 1);
    if (ip == 30) return sum;
    if (30 - ip >= 64) return '0;
    s = int'(30 - ip);
    return (sum + (64'd1 << (s - 1))) >> s;
  endfunction

  task automatic clear_sums();
    n_pairs = '0;
    sum_x = '0;
    sum_y = '0;
    sum_xy = '0;
    sum_xx = '0;
    too_many = 1'b0;
  endtask

  // Folds a word into the sums unless full, and on the last pair queues the fit.
  task automatic fold_pair(input pair_t p);
    longint              x, y;
    logic signed [127:0] n, sx, sy, sxy, sxx, den;
    longint              k0, k1;
    result_t             r;
    if (n_pairs < MAX_POINTS) begin
      x = log_q20({16'b0, p.mass_value}, 48);
      y = log_q20({32'b0, p.speed_value}, 22);
      sum_x = sum_x + x[47:0];
      sum_y = sum_y + y[47:0];
      sum_xy = sum_xy + x * y;
      sum_xx = sum_xx + x * x;
      n_pairs = n_pairs + 1;
    end else begin
      too_many = 1'b1;
    end
    if (!p.last_point) return;
    n = {117'b0, n_pairs};
    sx = {{80{sum_x[47]}}, sum_x};
    sy = {{80{sum_y[47]}}, sum_y};
    sxy = {{64{sum_xy[63]}}, sum_xy};
    sxx = {{64{sum_xx[63]}}, sum_xx};
    den = n * sxx - sx * sx;
    r = '0;
    r.points_used = n_pairs;
    if (den == 0) begin
      r.fit_status = ST_SINGULAR;
    end else begin
      k1 = quotient_sat((n * sxy - sx * sy) << 32, den);
      k0 = quotient_sat((sxx * sy - sx * sxy) << 12, den);
      r.exponent = k1[47:0];
      r.log_coefficient = k0[47:0];
      r.coefficient = coefficient_of(k0);
      r.fit_status = too_many ? ST_OVERFLOW : ST_OK;
    end
    fit_expected_q.push_back(r);
    clear_sums();
  endtask

  task automatic send_pair(input logic [47:0] m, input logic [31:0] s, input bit last);
    pair_t p;
    p.mass_value = m;
    p.speed_value = s;
    p.last_point = last;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start = 1'b1;
    pair = p;
    do @(posedge clk); while (busy);
    fold_pair(p);
    pairs_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (fit_expected_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (fit_expected_q.size() == 0) begin
        $display("%0t: fit result with none expected: %p", $time, result);
        error_count++;
      end else begin
        want = fit_expected_q.pop_front();
        fits_checked++;
        if (result.exponent !== want.exponent) begin
          $display("%0t: exponent expected %h got %h", $time, want.exponent, result.exponent);
          error_count++;
        end
        if (result.log_coefficient !== want.log_coefficient) begin
          $display("%0t: log_coefficient expected %h got %h", $time,
                   want.log_coefficient, result.log_coefficient);
          error_count++;
        end
        if (result.coefficient !== want.coefficient) begin
          $display("%0t: coefficient expected %h got %h", $time,
                   want.coefficient, result.coefficient);
          error_count++;
        end
        if (result.points_used !== want.points_used) begin
          $display("%0t: points_used expected %0d got %0d", $time,
                   want.points_used, result.points_used);
          error_count++;
        end
        if (result.fit_status !== want.fit_status) begin
          $display("%0t: fit_status expected %0d got %0d", $time,
                   want.fit_status, result.fit_status);
          error_count++;
        end
      end
    end
  end

  function automatic logic [47:0] pick_mass();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return '0;
      1: return raw[47:0] >> $urandom_range(47);
      2: return '1;
      default: return raw[47:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom >> $urandom_range(31);
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_pair('0, '0, 1'b0);
    send_pair(48'd1, 32'd1, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair('1, '0, 1'b0);
    send_pair('0, '1, 1'b0);
    send_pair(48'h8000_0000_0000, 32'h0040_0000, 1'b1);
    // Tiny masses with huge speeds push the intercept high.
    send_pair(48'd1, '1, 1'b0);
    send_pair(48'd2, '1, 1'b1);
    send_pair('1, 32'd1, 1'b0);
    send_pair(48'h7FFF_FFFF_FFFF, 32'd3, 1'b1);
    drain();
  endtask

  task automatic test_singular();
    send_pair(48'h1234_5678_9ABC, 32'h00C0_0000, 1'b1);
    send_pair(48'h0000_0100_0000, 32'h0000_1000, 1'b0);
    send_pair(48'h0000_0100_0000, 32'h0800_0000, 1'b0);
    send_pair(48'h0000_0100_0000, 32'hFFFF_0000, 1'b1);
    drain();
  endtask

  task automatic test_too_many_pairs();
    for (int i = 0; i < MAX_POINTS + 5; i++)
      send_pair(pick_mass(), pick_speed(), i == MAX_POINTS + 4);
    drain();
  endtask

  task automatic test_random_sets(input int pct);
    int sent, len;
    logic [47:0] m;
    idle_pct = pct;
    sent = 0;
    while (sent < RANDOM_PAIRS / 4) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 8);
      m = pick_mass();
      for (int i = 0; i < len; i++) begin
        // Now and then a mass repeats so that all x can coincide.
        if ($urandom_range(3) != 0 || len > 4) m = pick_mass();
        send_pair(m, pick_speed(), i == len - 1);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    clear_sums();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_singular();
    test_too_many_pairs();
    test_random_sets(0);
    test_random_sets(54);
    test_random_sets(0);
    test_random_sets(7);
    $display("Sent %0d pairs, checked %0d fits: extremes, singular sets,", pairs_sent,
             fits_checked);
    $display("an oversized set and random sets under several idle patterns.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
